### rtl/core/keypad_code_lock_top_defines.svh
// Assertion macros used by the checker file kcl_chk.sv.
`ifndef KEYPAD_CODE_LOCK_TOP_DEFINES_SVH
`define KEYPAD_CODE_LOCK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/kcl_pkg.sv
package kcl_pkg;

	localparam int unsigned MAX_DIGITS_DEF = 7;
	// Entry buffer never holds more than this many keys.
	localparam int unsigned DIGIT_CAP = 7;

	localparam int unsigned CODE_W    = 56;
	localparam int unsigned LEN_W     = 3;
	localparam int unsigned MISS_W    = 4;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned KEY_W     = 8;
	localparam int unsigned REQ_W     = 2;
	localparam int unsigned LMODE_W   = 2;
	localparam int unsigned EV_W      = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CODE_W-1:0] CODE_BYTES_RST     = 56'd875770417;
	localparam logic [LEN_W-1:0]  CODE_LENGTH_RST    = 3'd4;
	localparam logic [MISS_W-1:0] ALLOWED_MISSES_RST = 4'd3;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST  = 16'd8000;

	localparam logic [KEY_W-1:0] KEY_ENTER = 8'd35;

	localparam logic [CFG_IDX_W-1:0] CFG_CODE_BYTES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_MISSES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd3;

	localparam logic [REQ_W-1:0] REQ_WAKE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_KEY  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

	localparam logic [LMODE_W-1:0] LM_LOCKED   = 2'd0;
	localparam logic [LMODE_W-1:0] LM_ENTRY    = 2'd1;
	localparam logic [LMODE_W-1:0] LM_UNLOCKED = 2'd2;
	localparam logic [LMODE_W-1:0] LM_LOCKDOWN = 2'd3;

	localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
	localparam logic [EV_W-1:0] EV_KEY      = 3'd1;
	localparam logic [EV_W-1:0] EV_CORRECT  = 3'd2;
	localparam logic [EV_W-1:0] EV_WRONG    = 3'd3;
	localparam logic [EV_W-1:0] EV_LOCKDOWN = 3'd4;
	localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd5;

	typedef enum logic [3:0] {
		ST_LOCKED   = 4'b0001,
		ST_ENTRY    = 4'b0010,
		ST_UNLOCKED = 4'b0100,
		ST_LOCKDOWN = 4'b1000
	} lock_state_t;

	typedef struct packed {
		logic store;
		logic clear;
	} entry_ctl_t;

	function automatic logic [LMODE_W-1:0] lock_mode_enc(lock_state_t st);
		logic [LMODE_W-1:0] m;
		unique case (st)
			ST_LOCKED:   m = LM_LOCKED;
			ST_ENTRY:    m = LM_ENTRY;
			ST_UNLOCKED: m = LM_UNLOCKED;
			ST_LOCKDOWN: m = LM_LOCKDOWN;
			default:     m = LM_LOCKED;
		endcase
		return m;
	endfunction

endpackage

### rtl/core/kcl_entry.sv
module kcl_entry #(
	parameter int unsigned MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kcl_pkg::entry_ctl_t         ctl,
	input  logic [kcl_pkg::KEY_W-1:0]   key,
	input  logic [kcl_pkg::CODE_W-1:0]  code_bytes,
	input  logic [kcl_pkg::LEN_W-1:0]   code_length,
	output logic                        match
);
	import kcl_pkg::*;

	localparam int unsigned DEPTH = (MAX_DIGITS < DIGIT_CAP) ? MAX_DIGITS : DIGIT_CAP;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	logic [KEY_W-1:0] keys_q [DEPTH];
	logic [CW-1:0]    count_q;
	logic             ovf_q;
	logic             all_eq;
	logic             has_room;

	assign has_room = count_q < CW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.store) begin
			if (has_room) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Write the key into the next free slot; drop it when full.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (ctl.store && !ctl.clear && count_q == CW'(i)) begin
				keys_q[i] <= key;
			end
		end
	end

	always_comb begin
		all_eq = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			if (CW'(i) < count_q && keys_q[i] != code_bytes[8*i +: 8]) begin
				all_eq = 1'b0;
			end
		end
	end

	assign match = !ovf_q && (LEN_W'(count_q) == code_length) && all_eq;

endmodule

### rtl/core/keypad_code_lock_top.sv
// Keypad code lock. Each word on the input channel is a wake event, a key press or a
// timer tick, and produces exactly one result word (mode, event, misses left, buzzer,
// entry lamp). A new word is accepted every clock cycle unless the output stalls. A
// result goes from the input register through one state update pass into the result
// register, where it waits while the next word is already taken in. The code compare
// over all stored keys is done in parallel within that single pass, with no clearing
// pass after reset. Write configuration only while the block is idle (not enforced).
module keypad_code_lock_top #(
	parameter int unsigned MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kcl_pkg::CODE_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kcl_pkg::REQ_W-1:0]       req_type,
	input  logic [kcl_pkg::KEY_W-1:0]       key_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [kcl_pkg::LMODE_W-1:0]     lock_mode,
	output logic [kcl_pkg::EV_W-1:0]        event_code,
	output logic [kcl_pkg::MISS_W-1:0]      misses_left,
	output logic                            buzzer_on,
	output logic                            entry_lamp
);
	import kcl_pkg::*;

	logic [CODE_W-1:0] code_bytes_q;
	logic [LEN_W-1:0]  code_length_q;
	logic [MISS_W-1:0] allowed_misses_q;
	logic [TICK_W-1:0] timeout_ticks_q;

	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [KEY_W-1:0]  key_s1;

	lock_state_t       state_q, state_d;
	logic [MISS_W-1:0] miss_q, miss_d, miss_inc;
	logic [TICK_W-1:0] idle_q, idle_d, idle_inc;
	logic              run_q, run_d;
	logic [EV_W-1:0]   ev_d;
	logic [MISS_W-1:0] left_d;
	entry_ctl_t        ectl;
	logic              match;

	logic              out_valid_q;
	logic              advance, fire;

	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bytes_q     <= CODE_BYTES_RST;
			code_length_q    <= CODE_LENGTH_RST;
			allowed_misses_q <= ALLOWED_MISSES_RST;
			timeout_ticks_q  <= TIMEOUT_TICKS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CODE_BYTES:     code_bytes_q     <= cfg_wdata;
				CFG_CODE_LENGTH:    code_length_q    <= cfg_wdata[LEN_W-1:0];
				CFG_ALLOWED_MISSES: allowed_misses_q <= cfg_wdata[MISS_W-1:0];
				CFG_TIMEOUT_TICKS:  timeout_ticks_q  <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_type;
			key_s1 <= key_code;
		end
	end

	kcl_entry #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_entry (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ectl),
		.key         (key_s1),
		.code_bytes  (code_bytes_q),
		.code_length (code_length_q),
		.match       (match)
	);

	always_comb begin
		state_d    = state_q;
		miss_d     = miss_q;
		idle_d     = idle_q;
		run_d      = run_q;
		ev_d       = EV_NONE;
		ectl.store = 1'b0;
		ectl.clear = 1'b0;
		miss_inc   = (miss_q == '1) ? miss_q : miss_q + MISS_W'(1);
		idle_inc   = (idle_q == '1) ? idle_q : idle_q + TICK_W'(1);
		unique case (req_s1)
			REQ_WAKE: begin
				if (state_q != ST_LOCKDOWN) begin
					state_d = ST_ENTRY;
					idle_d  = '0;
					run_d   = 1'b1;
				end
			end
			REQ_KEY: begin
				if (state_q == ST_ENTRY) begin
					if (key_s1 == KEY_ENTER) begin
						ectl.clear = 1'b1;
						if (match) begin
							state_d = ST_UNLOCKED;
							miss_d  = '0;
							run_d   = 1'b0;
							idle_d  = '0;
							ev_d    = EV_CORRECT;
						end else begin
							miss_d = miss_inc;
							idle_d = '0;
							if (miss_inc >= allowed_misses_q) begin
								state_d = ST_LOCKDOWN;
								run_d   = 1'b0;
								ev_d    = EV_LOCKDOWN;
							end else begin
								run_d = 1'b1;
								ev_d  = EV_WRONG;
							end
						end
					end else begin
						ectl.store = 1'b1;
						idle_d     = '0;
						run_d      = 1'b1;
						ev_d       = EV_KEY;
					end
				end
			end
			REQ_TICK: begin
				if (state_q == ST_ENTRY && run_q) begin
					idle_d = idle_inc;
					// Timeout of zero behaves as one tick.
					if (idle_inc >= timeout_ticks_q) begin
						state_d = ST_LOCKED;
						run_d   = 1'b0;
						idle_d  = '0;
						ev_d    = EV_TIMEOUT;
					end
				end
			end
			default: ;
		endcase
		ectl.store = ectl.store && fire;
		ectl.clear = ectl.clear && fire;
		left_d = (allowed_misses_q > miss_d) ? allowed_misses_q - miss_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOCKED;
			miss_q      <= '0;
			idle_q      <= '0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_d;
				miss_q  <= miss_d;
				idle_q  <= idle_d;
				run_q   <= run_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Buzzer and lamp follow the state: lockdown is permanent, the lamp marks entry.
	always_ff @(posedge clk) begin
		if (fire) begin
			lock_mode   <= lock_mode_enc(state_d);
			event_code  <= ev_d;
			misses_left <= left_d;
			buzzer_on   <= (state_d == ST_LOCKDOWN);
			entry_lamp  <= (state_d == ST_ENTRY);
		end
	end

endmodule

### rtl/core/kcl_chk.sv
`include "keypad_code_lock_top_defines.svh"

module kcl_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [kcl_pkg::LMODE_W-1:0]     lock_mode,
	input logic [kcl_pkg::EV_W-1:0]        event_code,
	input logic [kcl_pkg::MISS_W-1:0]      misses_left,
	input logic                            buzzer_on,
	input logic                            entry_lamp
);
	import kcl_pkg::*;

	`KCL_ASSERT_IMP(a_flags_track_mode, clk, arst_n, out_valid, (buzzer_on == (lock_mode == LM_LOCKDOWN)) && (entry_lamp == (lock_mode == LM_ENTRY)), "buzzer or lamp out of step with mode")
	`KCL_ASSERT_IMP(a_lockdown_event, clk, arst_n, out_valid && (event_code == EV_LOCKDOWN), (lock_mode == LM_LOCKDOWN) && (misses_left == '0), "lockdown event without lockdown mode")
	`KCL_ASSERT_NXT(a_lockdown_sticks, clk, arst_n, out_valid && out_ready && (lock_mode == LM_LOCKDOWN), !out_valid || (lock_mode == LM_LOCKDOWN), "lockdown left without reset")
	`KCL_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(lock_mode) && $stable(event_code) && $stable(misses_left), "stalled result word changed")

endmodule

bind keypad_code_lock_top kcl_chk u_kcl_chk (.*);
